@@ rtl/core/jfs_pkg.sv @@
// Shared types and codes for the JPEG frame size scanner.
// No dependencies; imported by jpeg_frame_size_scanner.
`default_nettype none

package jfs_pkg;

    // Signature and marker bytes
    localparam logic [7:0]  SIG_HI      = 8'hFF;
    localparam logic [7:0]  SIG_SOI     = 8'hD8;
    localparam logic [15:0] TAG_SOF0    = 16'hFFC0;
    localparam logic [15:0] MIN_SEG_LEN = 16'd2;

    // Power-on marker limit
    localparam logic [7:0]  MAX_MARKERS_RST = 8'd10;

    // Result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_JPEG  = 3'd1;
    localparam logic [2:0] ST_SHORT_LEN = 3'd2;
    localparam logic [2:0] ST_MARKER_LIM = 3'd3;
    localparam logic [2:0] ST_TRUNCATED = 3'd4;

    // Frame header byte positions, counted from the first length byte
    localparam logic [2:0] SOF_H_HI = 3'd3;
    localparam logic [2:0] SOF_H_LO = 3'd4;
    localparam logic [2:0] SOF_W_HI = 3'd5;
    localparam logic [2:0] SOF_W_LO = 3'd6;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_last;
    } in_req_t;

    typedef struct packed {
        logic [16:0] frame_width;
        logic [16:0] frame_height;
        logic [2:0]  scan_status;
    } out_req_t;

endpackage

`default_nettype wire

@@ rtl/core/jpeg_frame_size_scanner.sv @@
// A request that decides the parse shows its result in the cycle after acceptance.
// Throughput: one byte per cycle; the byte parser is a single state update per request.
// A finished result that waits for m_ready holds s_ready low until it drains.
// Reset: aresetn is synchronous, active low; it clears the parse state, drops m_valid
// and sets max_markers to 10.
// Depends on jfs_pkg.
`default_nettype none

module jpeg_frame_size_scanner
    import jfs_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    // byte stream
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_req_t  s_data,
    // frame size results
    output logic          m_valid,
    input  wire logic     m_ready,
    output out_req_t      m_data,
    // marker limit register
    input  wire logic       cfg_wr_en,
    input  wire logic [7:0] cfg_wr_data
);

    typedef enum logic [2:0] {
        PH_SIG0,   // expect FF
        PH_SIG1,   // expect D8
        PH_TAG,    // two tag bytes
        PH_LEN,    // two length bytes
        PH_SKIP,   // segment payload
        PH_SOF     // frame header fields
    } phase_t;

    phase_t      phase_reg,        phase_next;
    logic [2:0]  idx_reg,          idx_next;
    logic [15:0] skip_reg,         skip_next;
    logic [7:0]  markers_reg,      markers_next;
    logic [15:0] tag_reg,          tag_next;
    logic [15:0] height_reg,       height_next;
    logic        given_reg,        given_next;
    logic [7:0]  max_markers_reg;
    logic        m_valid_reg,      m_valid_next;
    out_req_t    m_data_reg,       m_data_next;

    logic        accept;
    logic        emit;
    logic [2:0]  status;
    logic [16:0] width_even, height_even;
    logic [15:0] tag_full, width_full;
    logic [7:0]  markers_inc;

    // Take a new byte whenever the result register is empty or being drained.
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign tag_full    = {tag_reg[15:8], s_data.data_byte};
    assign width_full  = {tag_reg[15:8], s_data.data_byte};
    assign markers_inc = markers_reg + 8'd1;
    // Round up to even; an odd 65535 carries into bit 16.
    assign width_even  = {1'b0, width_full} + {16'd0, width_full[0]};
    assign height_even = {1'b0, height_reg} + {16'd0, height_reg[0]};

    // Parse step for the byte on the input, valid when accept is high.
    always_comb begin
        phase_next   = phase_reg;
        idx_next     = idx_reg;
        skip_next    = skip_reg;
        markers_next = markers_reg;
        tag_next     = tag_reg;
        height_next  = height_reg;
        given_next   = given_reg;
        emit         = 1'b0;
        status       = ST_OK;

        if (!given_reg) begin
            case (phase_reg)
                PH_SIG0: begin
                    if (s_data.data_byte == SIG_HI) begin
                        phase_next = PH_SIG1;
                    end else begin
                        emit   = 1'b1;
                        status = ST_NOT_JPEG;
                    end
                end
                PH_SIG1: begin
                    if (s_data.data_byte != SIG_SOI) begin
                        emit   = 1'b1;
                        status = ST_NOT_JPEG;
                    end else if (markers_reg >= max_markers_reg) begin
                        // limit of zero gives up before any marker
                        emit   = 1'b1;
                        status = ST_MARKER_LIM;
                    end else begin
                        phase_next = PH_TAG;
                        idx_next   = 3'd0;
                    end
                end
                PH_TAG: begin
                    if (idx_reg == 3'd0) begin
                        tag_next = {s_data.data_byte, 8'd0};
                        idx_next = 3'd1;
                    end else begin
                        tag_next   = tag_full;
                        idx_next   = 3'd0;
                        phase_next = (tag_full == TAG_SOF0) ? PH_SOF : PH_LEN;
                    end
                end
                PH_LEN: begin
                    if (idx_reg == 3'd0) begin
                        tag_next = {s_data.data_byte, 8'd0};
                        idx_next = 3'd1;
                    end else begin
                        tag_next = tag_full;
                        idx_next = 3'd0;
                        if (tag_full < MIN_SEG_LEN) begin
                            // length check wins over the marker limit
                            emit   = 1'b1;
                            status = ST_SHORT_LEN;
                        end else begin
                            markers_next = markers_inc;
                            skip_next    = tag_full - MIN_SEG_LEN;
                            if (markers_inc >= max_markers_reg) begin
                                emit   = 1'b1;
                                status = ST_MARKER_LIM;
                            end else if (tag_full == MIN_SEG_LEN) begin
                                phase_next = PH_TAG;
                            end else begin
                                phase_next = PH_SKIP;
                            end
                        end
                    end
                end
                PH_SKIP: begin
                    skip_next = skip_reg - 16'd1;
                    if (skip_reg == 16'd1) begin
                        phase_next = PH_TAG;
                        idx_next   = 3'd0;
                    end
                end
                PH_SOF: begin
                    case (idx_reg)
                        SOF_H_HI: height_next = {s_data.data_byte, 8'd0};
                        SOF_H_LO: height_next = {height_reg[15:8], s_data.data_byte};
                        SOF_W_HI: tag_next    = {s_data.data_byte, 8'd0};
                        SOF_W_LO: begin
                            emit   = 1'b1;
                            status = ST_OK;
                        end
                        default: ;
                    endcase
                    if (idx_reg < SOF_W_LO) begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
                default: ;
            endcase

            // End of file before a decision
            if (!emit && s_data.is_last) begin
                emit   = 1'b1;
                status = ST_TRUNCATED;
            end
        end

        if (emit) begin
            given_next = 1'b1;
        end

        // Restart the parse after the last byte of a file.
        if (s_data.is_last) begin
            phase_next   = PH_SIG0;
            idx_next     = 3'd0;
            skip_next    = 16'd0;
            markers_next = 8'd0;
            tag_next     = 16'd0;
            height_next  = 16'd0;
            given_next   = 1'b0;
        end
    end

    // Result register: drop on drain, load on a deciding request.
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (accept && emit) begin
            m_valid_next             = 1'b1;
            m_data_next.scan_status  = status;
            m_data_next.frame_width  = (status == ST_OK) ? width_even  : 17'd0;
            m_data_next.frame_height = (status == ST_OK) ? height_even : 17'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_SIG0;
            idx_reg         <= 3'd0;
            skip_reg        <= 16'd0;
            markers_reg     <= 8'd0;
            tag_reg         <= 16'd0;
            height_reg      <= 16'd0;
            given_reg       <= 1'b0;
            max_markers_reg <= MAX_MARKERS_RST;
            m_valid_reg     <= 1'b0;
        end else begin
            if (accept) begin
                phase_reg   <= phase_next;
                idx_reg     <= idx_next;
                skip_reg    <= skip_next;
                markers_reg <= markers_next;
                tag_reg     <= tag_next;
                height_reg  <= height_next;
                given_reg   <= given_next;
            end
            if (cfg_wr_en) begin
                max_markers_reg <= cfg_wr_data;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload register needs no reset.
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    // Sizes are only reported with an ok status.
    a_zero_unless_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.scan_status != ST_OK) |->
        (m_data_reg.frame_width == 17'd0 && m_data_reg.frame_height == 17'd0))
        else $error("nonzero size with failing status");

    // Reported sizes are even.
    a_even_sizes: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.scan_status == ST_OK) |->
        (!m_data_reg.frame_width[0] && !m_data_reg.frame_height[0]))
        else $error("odd frame size reported");

    // The last byte always restarts the parse.
    a_restart_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_data.is_last) |=> (phase_reg == PH_SIG0 && !given_reg
                                         && markers_reg == 8'd0))
        else $error("parse not restarted after last byte");

    // A result mid-file blocks further results until the file ends.
    a_one_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && given_reg) |-> !emit)
        else $error("second result for one file");

    // A file that ends without a decision still yields a result.
    a_last_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_data.is_last && !given_reg) |=> m_valid_reg)
        else $error("no result on last byte");

endmodule

`default_nettype wire
